### hdl/bfws_pkg.sv
// Package for the binned feature weight scorer.
// Holds the operation codes, the table write command type and fixed widths.
// No dependencies.
`timescale 1ns / 1ps

package bfws_pkg;

    localparam int DATA_W   = 64;
    localparam int SLOT_W   = 7;
    localparam int BIN_W    = 4;
    localparam int FEAT_MAX = 8;
    localparam int NARROW_W = 32;

    localparam logic [DATA_W-1:0] SCORE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum logic [1:0] {
        OP_SCORE  = 2'd0,
        OP_EDGE   = 2'd1,
        OP_WEIGHT = 2'd2
    } t_op;

    typedef struct packed {
        logic              edge_we;
        logic              weight_we;
        logic [BIN_W-1:0]  bin;
        logic [DATA_W-1:0] data;
    } t_tbl_wr;

endpackage

### hdl/bfws_feature_lane.sv
// One feature lane: edge and weight rows of one feature, bin search and weight pick.
// Depends on bfws_pkg.
`timescale 1ns / 1ps

module bfws_feature_lane
    import bfws_pkg::*;
#(
    parameter int BIN_LIMIT = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tbl_wr           i_wr,
    input  logic [DATA_W-1:0] i_value,
    input  logic [BIN_W-1:0]  i_nbins,
    output logic [DATA_W-1:0] o_weight
);

    logic [DATA_W-1:0] r_edge   [BIN_LIMIT-1];
    logic [DATA_W-1:0] r_weight [BIN_LIMIT];

    logic [BIN_W-1:0]  bin;
    logic [DATA_W-1:0] picked;
    logic              found;
    logic              count_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BIN_LIMIT - 1; k++) begin
                r_edge[k] <= '0;
            end
            for (int k = 0; k < BIN_LIMIT; k++) begin
                r_weight[k] <= '0;
            end
        end else begin
            for (int k = 0; k < BIN_LIMIT - 1; k++) begin
                if (i_wr.edge_we && i_wr.bin == BIN_W'(k)) begin
                    r_edge[k] <= i_wr.data;
                end
            end
            for (int k = 0; k < BIN_LIMIT; k++) begin
                if (i_wr.weight_we && i_wr.bin == BIN_W'(k)) begin
                    r_weight[k] <= i_wr.data;
                end
            end
        end
    end

    always_comb begin
        bin   = i_nbins - BIN_W'(1);
        found = 1'b0;
        for (int k = 0; k < BIN_LIMIT - 1; k++) begin
            if (!found && BIN_W'(k + 1) < i_nbins && i_value < r_edge[k]) begin
                bin   = BIN_W'(k);
                found = 1'b1;
            end
        end
        if (bin > BIN_W'(BIN_LIMIT - 1)) begin
            bin = BIN_W'(BIN_LIMIT - 1);
        end
        picked = '0;
        for (int k = 0; k < BIN_LIMIT; k++) begin
            if (bin == BIN_W'(k)) begin
                picked = r_weight[k];
            end
        end
        count_ok = (i_nbins != '0) && (i_nbins <= BIN_W'(BIN_LIMIT));
        o_weight = count_ok ? picked : '0;
    end

endmodule

### hdl/binned_feature_weight_scorer.sv
// Binned feature weight scorer: input stage, feature lanes, weight sum and result register.
// Depends on bfws_pkg and bfws_feature_lane.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one transaction per item: op 0 scores
//   the eight features, op 1 writes a bin edge and op 2 a bin weight at i_table_slot
//   (feature * BIN_LIMIT + bin). Loads and op 3 give no result. A score gives one
//   transaction on the output channel (o_out_valid / i_out_ready) with o_score.
//   The configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
//   packed bin counts; write it only while no score is in flight.
//   A score passes the input register, lane weight register, half-sum register and
//   result register in that order before it shows on o_score.
//   Throughput: one transaction per cycle unless a stalled receiver has filled the pipeline;
//   every stage has its own valid bit and moves whenever the next stage is empty or moving,
//   so input stays open while a result waits. A stalled receiver holds the result and fills
//   the pipeline behind it; o_in_ready drops only when all stages are full.
//   Reset clears the edge and weight tables, the bin counts and all valid bits.
`timescale 1ns / 1ps

module binned_feature_weight_scorer
    import bfws_pkg::*;
#(
    parameter int FEATURE_COUNT = 8,
    parameter int BIN_LIMIT     = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [NARROW_W-1:0]      i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_op,
    input  logic [SLOT_W-1:0]        i_table_slot,
    input  logic [DATA_W-1:0]        i_load_value,
    input  logic                     i_record_valid,
    input  logic [DATA_W-1:0]        i_page_delta,
    input  logic [DATA_W-1:0]        i_file_size,
    input  logic [NARROW_W-1:0]      i_page_hotness,
    input  logic [NARROW_W-1:0]      i_seq_distance,
    input  logic [DATA_W-1:0]        i_page_delta_prev,
    input  logic [DATA_W-1:0]        i_file_delta,
    input  logic [DATA_W-1:0]        i_file_delta_prev,
    input  logic [NARROW_W-1:0]      i_file_hotness,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_score
);

    localparam int HALF = FEAT_MAX / 2;

    logic [NARROW_W-1:0] r_bin_counts;

    logic                r1_valid;
    logic [1:0]          r1_op;
    logic [SLOT_W-1:0]   r1_slot;
    logic [DATA_W-1:0]   r1_load_value;
    logic                r1_rec;
    logic [DATA_W-1:0]   r1_feat [FEAT_MAX];

    logic                r2_valid;
    logic                r2_rec;
    logic [DATA_W-1:0]   r2_weight [FEATURE_COUNT];

    logic                r3_valid;
    logic                r3_rec;
    logic [DATA_W-1:0]   r3_half [2];

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_score;

    logic                is_score;
    logic                is_edge;
    logic                is_weight;
    logic                out_ready;
    logic                s3_ready;
    logic                s2_ready;
    logic                s1_to_s2;
    logic                s1_ready;
    logic [DATA_W-1:0]   lane_weight [FEATURE_COUNT];
    t_tbl_wr             lane_wr [FEATURE_COUNT];
    logic [DATA_W-1:0]   n_half [2];
    logic [DATA_W-1:0]   n_score;

    // Opcode decode of the input stage
    always_comb begin
        is_score  = 1'b0;
        is_edge   = 1'b0;
        is_weight = 1'b0;
        unique case (t_op'(r1_op))
            OP_SCORE:  is_score  = 1'b1;
            OP_EDGE:   is_edge   = 1'b1;
            OP_WEIGHT: is_weight = 1'b1;
            default: ;
        endcase
    end

    assign out_ready   = !r_out_valid || i_out_ready;
    assign s3_ready    = !r3_valid || out_ready;
    assign s2_ready    = !r2_valid || s3_ready;
    assign s1_to_s2    = r1_valid && is_score && s2_ready;
    assign s1_ready    = !r1_valid || !is_score || s2_ready;
    assign o_in_ready  = s1_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_score     = $signed(r_score);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_counts <= '0;
            r1_valid     <= 1'b0;
            r2_valid     <= 1'b0;
            r3_valid     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bin_counts <= i_cfg_data;
            end
            if (s1_ready) begin
                r1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r2_valid <= s1_to_s2;
            end
            if (s3_ready) begin
                r3_valid <= r2_valid;
            end
            if (out_ready) begin
                r_out_valid <= r3_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && s1_ready) begin
            r1_op         <= i_op;
            r1_slot       <= i_table_slot;
            r1_load_value <= i_load_value;
            r1_rec        <= i_record_valid;
            r1_feat[0]    <= i_page_delta;
            r1_feat[1]    <= i_file_size;
            r1_feat[2]    <= {{(DATA_W-NARROW_W){1'b0}}, i_page_hotness};
            r1_feat[3]    <= {{(DATA_W-NARROW_W){1'b0}}, i_seq_distance};
            r1_feat[4]    <= i_page_delta_prev;
            r1_feat[5]    <= i_file_delta;
            r1_feat[6]    <= i_file_delta_prev;
            r1_feat[7]    <= {{(DATA_W-NARROW_W){1'b0}}, i_file_hotness};
        end
        if (s1_to_s2) begin
            r2_rec <= r1_rec;
            for (int f = 0; f < FEATURE_COUNT; f++) begin
                r2_weight[f] <= lane_weight[f];
            end
        end
        if (r2_valid && s3_ready) begin
            r3_rec     <= r2_rec;
            r3_half[0] <= n_half[0];
            r3_half[1] <= n_half[1];
        end
        if (r3_valid && out_ready) begin
            r_score <= n_score;
        end
    end

    genvar g;
    generate
        for (g = 0; g < FEATURE_COUNT; g++) begin : g_lane
            localparam int LO = g * BIN_LIMIT;
            localparam int HI = (g + 1) * BIN_LIMIT;

            logic hit;
            logic [SLOT_W:0] rel;

            assign hit = ({1'b0, r1_slot} >= (SLOT_W+1)'(LO))
                      && ({1'b0, r1_slot} < (SLOT_W+1)'(HI));
            assign rel = {1'b0, r1_slot} - (SLOT_W+1)'(LO);

            assign lane_wr[g].edge_we   = r1_valid && is_edge && hit;
            assign lane_wr[g].weight_we = r1_valid && is_weight && hit;
            assign lane_wr[g].bin       = rel[BIN_W-1:0];
            assign lane_wr[g].data      = r1_load_value;

            bfws_feature_lane #(
                .BIN_LIMIT (BIN_LIMIT)
            ) u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_wr     (lane_wr[g]),
                .i_value  (r1_feat[g]),
                .i_nbins  (r_bin_counts[BIN_W*g +: BIN_W]),
                .o_weight (lane_weight[g])
            );
        end
    endgenerate

    // Sum lane weights in two halves, then combine, or give SCORE_MAX for an invalid record
    always_comb begin
        n_half[0] = '0;
        n_half[1] = '0;
        for (int f = 0; f < FEATURE_COUNT; f++) begin
            if (f < HALF) begin
                n_half[0] = n_half[0] + r2_weight[f];
            end else begin
                n_half[1] = n_half[1] + r2_weight[f];
            end
        end
        n_score = r3_rec ? (r3_half[0] + r3_half[1]) : SCORE_MAX;
    end

endmodule

### bench/testbench.sv
// Self-checking bench for binned_feature_weight_scorer: table loads, bin count writes and scores.
// Scores are checked against an in-bench bin lookup and weight sum, with random stalls on both sides.
// Depends on bfws_pkg and the scorer RTL.
`timescale 1ns / 1ps

module testbench;
    import bfws_pkg::*;

    localparam int          FEATURE_COUNT = 8;
    localparam int          BIN_LIMIT     = 10;
    localparam int          TABLE_DEPTH   = FEATURE_COUNT * BIN_LIMIT;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          PHASES        = 6;
    localparam int          RANDOM_ITEMS  = 145;
    localparam logic [63:0] ALL_ONES      = '1;

    typedef struct packed {
        logic [1:0]        op;
        logic [6:0]        slot;
        logic [63:0]       load_value;
        logic              record_valid;
        logic [7:0][63:0]  feat;
    } t_item;

    typedef struct {
        bit          is_cfg;
        logic [31:0] cfg_value;
        t_item       item;
        bit          has_typed;
        logic [63:0] typed_score;
    } t_dir_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [NARROW_W-1:0]      i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [1:0]               i_op;
    logic [SLOT_W-1:0]        i_table_slot;
    logic [DATA_W-1:0]        i_load_value;
    logic                     i_record_valid;
    logic [DATA_W-1:0]        i_page_delta;
    logic [DATA_W-1:0]        i_file_size;
    logic [NARROW_W-1:0]      i_page_hotness;
    logic [NARROW_W-1:0]      i_seq_distance;
    logic [DATA_W-1:0]        i_page_delta_prev;
    logic [DATA_W-1:0]        i_file_delta;
    logic [DATA_W-1:0]        i_file_delta_prev;
    logic [NARROW_W-1:0]      i_file_hotness;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [DATA_W-1:0] o_score;

    logic [63:0] edge_mem [TABLE_DEPTH];
    logic [63:0] weight_mem [TABLE_DEPTH];
    logic [31:0] bin_cfg;
    logic [63:0] expected_scores [$];
    t_dir_row    dir_rows [$];

    int err_count;
    int score_count;
    int load_count;
    int other_count;
    int cfg_count;
    int cycle_count;
    int stall_left;

    binned_feature_weight_scorer #(
        .FEATURE_COUNT (FEATURE_COUNT),
        .BIN_LIMIT     (BIN_LIMIT)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_table_slot      (i_table_slot),
        .i_load_value      (i_load_value),
        .i_record_valid    (i_record_valid),
        .i_page_delta      (i_page_delta),
        .i_file_size       (i_file_size),
        .i_page_hotness    (i_page_hotness),
        .i_seq_distance    (i_seq_distance),
        .i_page_delta_prev (i_page_delta_prev),
        .i_file_delta      (i_file_delta),
        .i_file_delta_prev (i_file_delta_prev),
        .i_file_hotness    (i_file_hotness),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_score           (o_score)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int pick_len();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(15, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [63:0] predict_score(t_item it);
        logic [63:0] sum;
        logic [3:0]  nbins;
        int          bin;
        bit          found;
        if (!it.record_valid) begin
            return SCORE_MAX;
        end
        sum = '0;
        for (int f = 0; f < FEATURE_COUNT; f++) begin
            nbins = bin_cfg[4*f +: 4];
            if (nbins == 0 || nbins > BIN_LIMIT) begin
                continue;
            end
            bin   = nbins - 1;
            found = 1'b0;
            for (int k = 0; k + 1 < nbins && k + 1 < BIN_LIMIT; k++) begin
                if (!found && it.feat[f] < edge_mem[f*BIN_LIMIT + k]) begin
                    bin   = k;
                    found = 1'b1;
                end
            end
            if (bin > BIN_LIMIT - 1) begin
                bin = BIN_LIMIT - 1;
            end
            sum = sum + weight_mem[f*BIN_LIMIT + bin];
        end
        return sum;
    endfunction

    function automatic t_dir_row row_score(logic rec, logic [63:0] first, logic [63:0] rest,
                                           bit has_typed, logic [63:0] typed);
        t_dir_row r;
        r.is_cfg            = 1'b0;
        r.cfg_value         = '0;
        r.item.op           = OP_SCORE;
        r.item.slot         = '0;
        r.item.load_value   = '0;
        r.item.record_valid = rec;
        r.item.feat[0]      = first;
        for (int f = 1; f < 8; f++) begin
            r.item.feat[f] = rest;
        end
        r.has_typed   = has_typed;
        r.typed_score = typed;
        return r;
    endfunction

    function automatic t_dir_row row_load(logic [1:0] op, logic [6:0] slot, logic [63:0] val);
        t_dir_row r;
        r                 = row_score(1'b1, '0, '0, 1'b0, '0);
        r.item.op         = op;
        r.item.slot       = slot;
        r.item.load_value = val;
        return r;
    endfunction

    function automatic t_dir_row row_cfg(logic [31:0] val);
        t_dir_row r;
        r           = row_score(1'b1, '0, '0, 1'b0, '0);
        r.is_cfg    = 1'b1;
        r.cfg_value = val;
        return r;
    endfunction

    function automatic logic [63:0] pick_feature(int f);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2, 3:    return {$urandom, $urandom};
            4:       return 64'($urandom_range(0, 1000));
            default: return edge_mem[f*BIN_LIMIT + $urandom_range(0, BIN_LIMIT - 1)]
                            + 64'($urandom_range(0, 2)) - 64'd1;
        endcase
    endfunction

    function automatic logic [63:0] pick_weight();
        logic [63:0] w;
        if ($urandom_range(0, 1) == 0) begin
            return {$urandom, $urandom};
        end
        w = 64'($urandom_range(0, 2000));
        return w - 64'd1000;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    r;
        it.slot         = $urandom_range(0, 9) == 0 ? 7'($urandom_range(TABLE_DEPTH, 127))
                                                     : 7'($urandom_range(0, TABLE_DEPTH - 1));
        it.load_value   = {$urandom, $urandom};
        it.record_valid = $urandom_range(0, 19) != 0;
        for (int f = 0; f < 8; f++) begin
            it.feat[f] = pick_feature(f);
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            it.op = OP_EDGE;
            if ($urandom_range(0, 1) == 0) begin
                it.load_value = 64'($urandom);
            end
        end else if (r < 20) begin
            it.op         = OP_WEIGHT;
            it.load_value = pick_weight();
        end else if (r < 23) begin
            it.op = OP_UNUSED;
        end else begin
            it.op = OP_SCORE;
        end
        return it;
    endfunction

    task automatic send_item(input t_item it, input bit has_typed, input logic [63:0] typed);
        int gap;
        it.feat[2][63:32] = '0;
        it.feat[3][63:32] = '0;
        it.feat[7][63:32] = '0;
        gap = (cycle_count[11:10] == 2'b01 || $urandom_range(0, 1) == 0) ? 0 : pick_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_op              <= it.op;
        i_table_slot      <= it.slot;
        i_load_value      <= it.load_value;
        i_record_valid    <= it.record_valid;
        i_page_delta      <= it.feat[0];
        i_file_size       <= it.feat[1];
        i_page_hotness    <= it.feat[2][31:0];
        i_seq_distance    <= it.feat[3][31:0];
        i_page_delta_prev <= it.feat[4];
        i_file_delta      <= it.feat[5];
        i_file_delta_prev <= it.feat[6];
        i_file_hotness    <= it.feat[7][31:0];
        do @(posedge i_clk); while (!o_in_ready);
        if (it.op == OP_SCORE) begin
            score_count++;
            expected_scores.push_back(has_typed ? typed : predict_score(it));
        end else if (it.op == OP_EDGE || it.op == OP_WEIGHT) begin
            load_count++;
            if (it.slot < TABLE_DEPTH) begin
                if (it.op == OP_EDGE) begin
                    edge_mem[it.slot] = it.load_value;
                end else begin
                    weight_mem[it.slot] = it.load_value;
                end
            end
        end else begin
            other_count++;
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bins(input logic [31:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        bin_cfg = val;
        cfg_count++;
    endtask

    task automatic load_sorted_tables();
        logic [63:0] acc;
        t_item       it;
        it = random_item();
        for (int f = 0; f < FEATURE_COUNT; f++) begin
            acc = 64'($urandom_range(0, 100));
            for (int k = 0; k < BIN_LIMIT; k++) begin
                if (f == 2 || f == 3 || f == 7) begin
                    acc = acc + 64'($urandom_range(1, 1 << 24));
                end else begin
                    acc = acc + (64'($urandom) << $urandom_range(0, 27));
                end
                it.op         = OP_EDGE;
                it.slot       = 7'(f*BIN_LIMIT + k);
                it.load_value = acc;
                send_item(it, 1'b0, '0);
            end
        end
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            it.op         = OP_WEIGHT;
            it.slot       = 7'(s);
            it.load_value = pick_weight();
            send_item(it, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (cycle_count[9:8] != 2'b00 && $urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= pick_len() - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_scores.size() == 0) begin
                err_count++;
                $display("%0t: unexpected score transaction, expected none, got %h",
                         $time, o_score);
            end else begin
                if (o_score !== expected_scores[0]) begin
                    err_count++;
                    $display("%0t: score mismatch, expected %h, got %h",
                             $time, expected_scores[0], o_score);
                end
                void'(expected_scores.pop_front());
            end
        end
    end

    initial begin
        logic [31:0] cfg;
        err_count   = 0;
        score_count = 0;
        load_count  = 0;
        other_count = 0;
        cfg_count   = 0;
        cycle_count = 0;
        stall_left  = 0;
        bin_cfg     = '0;
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            edge_mem[s]   = '0;
            weight_mem[s] = '0;
        end
        i_rst_n           <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_data        <= '0;
        i_in_valid        <= 1'b0;
        i_op              <= OP_SCORE;
        i_table_slot      <= '0;
        i_load_value      <= '0;
        i_record_valid    <= 1'b0;
        i_page_delta      <= '0;
        i_file_size       <= '0;
        i_page_hotness    <= '0;
        i_seq_distance    <= '0;
        i_page_delta_prev <= '0;
        i_file_delta      <= '0;
        i_file_delta_prev <= '0;
        i_file_hotness    <= '0;
        i_out_ready       <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_rows.push_back(row_score(1'b1, '0, '0, 1'b1, '0));
        dir_rows.push_back(row_score(1'b0, ALL_ONES, ALL_ONES, 1'b1, SCORE_MAX));
        dir_rows.push_back(row_cfg(32'hAAAA_AAAA));
        dir_rows.push_back(row_score(1'b1, '0, '0, 1'b1, '0));
        dir_rows.push_back(row_load(OP_EDGE, 7'd0, 64'd100));
        dir_rows.push_back(row_load(OP_WEIGHT, 7'd0, 64'd5));
        dir_rows.push_back(row_load(OP_WEIGHT, 7'd9, -64'sd3));
        dir_rows.push_back(row_score(1'b1, 64'd99, '0, 1'b0, '0));
        dir_rows.push_back(row_score(1'b1, 64'd100, '0, 1'b0, '0));
        dir_rows.push_back(row_load(OP_WEIGHT, 7'd79, SCORE_MAX));
        dir_rows.push_back(row_load(OP_WEIGHT, 7'd69, 64'd1));
        dir_rows.push_back(row_score(1'b1, ALL_ONES, ALL_ONES, 1'b0, '0));
        dir_rows.push_back(row_load(OP_WEIGHT, 7'd80, 64'd55));
        dir_rows.push_back(row_load(OP_EDGE, 7'd127, ALL_ONES));
        dir_rows.push_back(row_load(OP_UNUSED, 7'd0, ALL_ONES));
        dir_rows.push_back(row_score(1'b1, '0, '0, 1'b0, '0));
        dir_rows.push_back(row_score(1'b0, '0, '0, 1'b1, SCORE_MAX));
        dir_rows.push_back(row_cfg(32'hFB10_03A2));
        dir_rows.push_back(row_load(OP_EDGE, 7'd1, ALL_ONES));
        dir_rows.push_back(row_score(1'b1, 64'd50, ALL_ONES, 1'b0, '0));
        dir_rows.push_back(row_score(1'b1, ALL_ONES, '0, 1'b0, '0));
        dir_rows.push_back(row_cfg(32'hFFFF_FFFF));
        dir_rows.push_back(row_score(1'b1, ALL_ONES, ALL_ONES, 1'b1, '0));
        dir_rows.push_back(row_cfg(32'h1111_1111));
        dir_rows.push_back(row_score(1'b1, ALL_ONES, ALL_ONES, 1'b0, '0));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_bins(dir_rows[i].cfg_value);
            end else begin
                send_item(dir_rows[i].item, dir_rows[i].has_typed, dir_rows[i].typed_score);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0, 5:    cfg = 32'hAAAA_AAAA;
                2:       cfg = $urandom;
                default: begin
                    for (int f = 0; f < FEATURE_COUNT; f++) begin
                        cfg[4*f +: 4] = 4'($urandom_range(1, BIN_LIMIT));
                    end
                end
            endcase
            write_bins(cfg);
            load_sorted_tables();
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                send_item(random_item(), 1'b0, '0);
            end
        end

        drain();
        $display("Covered %0d scores, %0d table loads, %0d unused-op transactions, %0d bin count writes",
                 score_count, load_count, other_count, cfg_count);
        $display("Directed extremes, wraparound, bad bin counts and %0d random phases; %0d mismatches",
                 PHASES, err_count);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
